### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each check is sampled on the rising edge of i_clk and is off while
// i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console character writer: command and
// result beats, the configuration set and the register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

    // Field widths fixed by the interface.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int CHAR_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_CODE     = 3'd4;

    // Register reset values.
    localparam logic [7:0] RST_COLUMNS        = 8'd80;
    localparam logic [6:0] RST_ROWS           = 7'd25;
    localparam logic       RST_SCROLL_ENABLE  = 1'b1;
    localparam logic [7:0] RST_BACKSPACE_CODE = 8'd8;
    localparam logic [7:0] RST_ENTER_CODE     = 8'd13;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    // Command modes.
    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  read_col;
        logic [ROW_W-1:0]  read_row;
    } t_cmd;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CHAR_W-1:0] cell_char;
        logic              scrolled;
    } t_result;

    typedef struct packed {
        logic [7:0] columns;
        logic [6:0] rows;
        logic       scroll_enable;
        logic [7:0] backspace_code;
        logic [7:0] enter_code;
    } t_cfg;

endpackage

### hdl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character-cell text console: glyph grid, cursor, scrolling and cell read.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                              | Handshake
//  ---------+------------------------------------+-------------------------
//  command  | start, busy, i_cmd                 | start high, busy low
//  result   | o_done, o_result                   | one-cycle strobe
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data    | write enable, no wait
//
// After reset the grid is swept to spaces, one cell a cycle, over all
// MAX_ROWS * 2**ceil(log2(MAX_COLS)) cells (8192 by default) with busy high.
// A put writes its cell when taken; a read waits in a read-out state for the
// registered grid read. A scroll walks the grid with one address counter: a
// copy pass over rows-1 rows, a drain step and a blanking pass after the put
// (no copy for one row). The result beat then follows; the receiver cannot stall it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_char_writer #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  tcw_pkg::t_cmd                      i_cmd,
    output logic                               o_done,
    output tcw_pkg::t_result                   o_result,
    input  logic                               i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import tcw_pkg::*;

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW    = CW + RW;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);

    t_cfg          r_cfg;
    logic          accept;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns        <= RST_COLUMNS;
            r_cfg.rows           <= RST_ROWS;
            r_cfg.scroll_enable  <= RST_SCROLL_ENABLE;
            r_cfg.backspace_code <= RST_BACKSPACE_CODE;
            r_cfg.enter_code     <= RST_ENTER_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS:        r_cfg.columns        <= i_cfg_data;
                CFG_ROWS:           r_cfg.rows           <= i_cfg_data[6:0];
                CFG_SCROLL_ENABLE:  r_cfg.scroll_enable  <= i_cfg_data[0];
                CFG_BACKSPACE_CODE: r_cfg.backspace_code <= i_cfg_data;
                CFG_ENTER_CODE:     r_cfg.enter_code     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A command beat is taken whenever start is high and the sequencer is idle.
    assign accept = start && !busy;

    tcw_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CW       (CW),
        .RW       (RW),
        .AW       (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (accept),
        .i_cmd       (i_cmd),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tcw_grid_ram #(
        .ADDR_W (AW),
        .DEPTH  (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // A result beat always lands with the sequencer back at idle.
    `ASSERT_SAME(a_done_idle, o_done, !busy)
    // A scroll always leaves the cursor at the start of a row.
    `ASSERT_SAME(a_scroll_col0, o_done && o_result.scrolled, o_result.cursor_col == '0)
    // A read beat is answered through the read-out state and the registered done flag.
    `ASSERT_NEXT(a_read_lat, accept && (i_cmd.mode == MODE_READ), ##1 o_done)

endmodule

### hdl/tcw_grid_ram.sv
// ----------------------------------------------------------------------------
// tcw_grid_ram
// Character grid storage: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_grid_ram #(
    parameter int ADDR_W = 13,
    parameter int DEPTH  = 8192
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tcw_seq.sv
// ----------------------------------------------------------------------------
// tcw_seq
// Cursor logic and grid sequencer. One address counter walks the grid for
// the clearing pass after reset, the row copy of a scroll and the blanking
// of the last row; puts and reads touch a single cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_seq #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int CW       = 7,
    parameter int RW       = 6,
    parameter int AW       = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcw_pkg::t_cfg     i_cfg,
    input  logic              i_start,
    input  tcw_pkg::t_cmd     i_cmd,
    output logic              o_busy,
    output logic              o_done,
    output tcw_pkg::t_result  o_result,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [7:0]        o_mem_wdata,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [7:0]        i_mem_rdata
);

    import tcw_pkg::*;

    localparam int NCW   = $clog2(MAX_COLS + 1);
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_ROWS * (2 ** CW);
    localparam logic [AW-1:0] STRIDE    = AW'(2 ** CW);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_RDOUT   = 6'b000100,
        S_COPY    = 6'b001000,
        S_COPYEND = 6'b010000,
        S_BLANK   = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cx, n_cx;
    logic [RW-1:0]   r_cy, n_cy;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_wa, n_wa;
    logic            r_wv, n_wv;
    logic [RW-1:0]   r_lrow, n_lrow;
    logic            r_oob, n_oob;
    logic            r_done, n_done;
    t_result         r_res, n_res;

    logic [NCW-1:0]  nc;
    logic [NRW-1:0]  nr;
    logic [RW-1:0]   row_last;
    logic [CW:0]     x_inc;
    logic [RW:0]     y_inc;
    logic            cr_wrap;
    logic [RW-1:0]   cr_y;
    logic            is_bs;
    logic            is_nl;
    logic            do_store;
    logic [CW-1:0]   p_x;
    logic [RW-1:0]   p_y;
    logic            p_cr;
    logic            p_we;
    logic            p_scroll;
    logic            rd_in_range;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   copy_end;
    logic [AW-1:0]   blank_end;

    // Effective window size, clamped to 1..MAX.
    always_comb begin
        if (i_cfg.columns == 8'd0) begin
            nc = NCW'(1);
        end else if ({1'b0, i_cfg.columns} > 9'(MAX_COLS)) begin
            nc = NCW'(MAX_COLS);
        end else begin
            nc = NCW'(i_cfg.columns);
        end
        if (i_cfg.rows == 7'd0) begin
            nr = NRW'(1);
        end else if ({1'b0, i_cfg.rows} > 8'(MAX_ROWS)) begin
            nr = NRW'(MAX_ROWS);
        end else begin
            nr = NRW'(i_cfg.rows);
        end
    end

    assign row_last = RW'(nr - NRW'(1));

    // Carriage return target row.
    assign y_inc   = {1'b0, r_cy} + (RW+1)'(1);
    assign cr_wrap = y_inc >= (RW+1)'(nr);
    assign cr_y    = cr_wrap ? row_last : y_inc[RW-1:0];

    // Put decode and cursor update.
    assign x_inc    = {1'b0, r_cx} + (CW+1)'(1);
    assign is_bs    = i_cmd.char_code == i_cfg.backspace_code;
    assign is_nl    = (i_cmd.char_code == CH_NEWLINE) || (i_cmd.char_code == i_cfg.enter_code);
    assign do_store = ((CW+1)'(r_cx) < (CW+1)'(nc)) && ((RW+1)'(r_cy) < (RW+1)'(nr));

    always_comb begin
        p_x  = r_cx;
        p_y  = r_cy;
        p_cr = 1'b0;
        p_we = 1'b0;
        if (is_bs) begin
            if (r_cx != '0) begin
                p_x = r_cx - CW'(1);
            end
        end else if (is_nl) begin
            p_cr = 1'b1;
        end else begin
            p_we = do_store;
            if (x_inc >= (CW+1)'(nc)) begin
                p_cr = 1'b1;
            end else begin
                p_x = x_inc[CW-1:0];
            end
        end
        if (p_cr) begin
            p_x = '0;
            p_y = cr_y;
        end
    end

    assign p_scroll = p_cr && cr_wrap && i_cfg.scroll_enable;

    // Read address and bounds check.
    assign rd_in_range = ({2'b00, i_cmd.read_col} < 9'(MAX_COLS))
                      && ({2'b00, i_cmd.read_row} < 8'(MAX_ROWS));
    assign rd_addr     = {RW'(i_cmd.read_row), CW'(i_cmd.read_col)};

    // Scroll sweep limits.
    assign copy_end  = {r_lrow, {CW{1'b0}}} - AW'(1);
    assign blank_end = {r_lrow, {CW{1'b1}}};

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_addr      = r_addr;
        n_wa        = r_wa;
        n_wv        = 1'b0;
        n_lrow      = r_lrow;
        n_oob       = r_oob;
        n_done      = 1'b0;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_addr;
        o_mem_wdata = CH_SPACE;
        o_mem_raddr = rd_addr;
        case (r_state)
            S_CLEAR: begin
                o_mem_we = 1'b1;
                n_addr   = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd.mode == MODE_READ) begin
                        n_oob   = !rd_in_range;
                        n_state = S_RDOUT;
                    end else begin
                        o_mem_we    = p_we;
                        o_mem_waddr = {r_cy, r_cx};
                        o_mem_wdata = i_cmd.char_code;
                        n_cx        = p_x;
                        n_cy        = p_y;
                        if (p_scroll) begin
                            n_lrow = row_last;
                            if (row_last != '0) begin
                                n_addr  = '0;
                                n_state = S_COPY;
                            end else begin
                                n_addr  = {row_last, {CW{1'b0}}};
                                n_state = S_BLANK;
                            end
                        end else begin
                            n_done           = 1'b1;
                            n_res.cursor_col = COL_W'(p_x);
                            n_res.cursor_row = ROW_W'(p_y);
                            n_res.cell_char  = '0;
                            n_res.scrolled   = 1'b0;
                        end
                    end
                end
            end
            S_RDOUT: begin
                n_done           = 1'b1;
                n_res.cursor_col = COL_W'(r_cx);
                n_res.cursor_row = ROW_W'(r_cy);
                n_res.cell_char  = r_oob ? CH_SPACE : i_mem_rdata;
                n_res.scrolled   = 1'b0;
                n_state          = S_IDLE;
            end
            S_COPY: begin
                // Read one row ahead, write the previous read back one row up.
                o_mem_raddr = r_addr + STRIDE;
                o_mem_we    = r_wv;
                o_mem_waddr = r_wa;
                o_mem_wdata = i_mem_rdata;
                n_wa        = r_addr;
                n_wv        = 1'b1;
                n_addr      = r_addr + AW'(1);
                if (r_addr == copy_end) begin
                    n_state = S_COPYEND;
                end
            end
            S_COPYEND: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_wa;
                o_mem_wdata = i_mem_rdata;
                n_addr      = {r_lrow, {CW{1'b0}}};
                n_state     = S_BLANK;
            end
            S_BLANK: begin
                o_mem_we = 1'b1;
                n_addr   = r_addr + AW'(1);
                if (r_addr == blank_end) begin
                    n_done           = 1'b1;
                    n_res.cursor_col = COL_W'(r_cx);
                    n_res.cursor_row = ROW_W'(r_cy);
                    n_res.cell_char  = '0;
                    n_res.scrolled   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cx    <= '0;
            r_cy    <= '0;
            r_addr  <= '0;
            r_wv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_addr  <= n_addr;
            r_wv    <= n_wv;
            r_done  <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_wa   <= n_wa;
        r_lrow <= n_lrow;
        r_oob  <= n_oob;
        r_res  <= n_res;
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### tb/text_console_char_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Self-checking bench for the text console character writer. A cycle-free
// model of the glyph grid, cursor and registers predicts every result beat.
// Directed tests cover field extremes, control codes and register limits.
// Random phases then switch window sizes and codes between bursts of traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_char_writer_tb;

    import tcw_pkg::*;

    localparam int GRID_COLS     = 128;
    localparam int GRID_ROWS     = 64;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int CALM_TAIL     = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 50;
    // The limit is well above a full 64-row scroll or the clearing sweep, both quiet.
    localparam int STALL_LIMIT   = 40000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_cmd                  i_cmd;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Console model state and the results still owed by the block.
    logic [CHAR_W-1:0] model_grid [GRID_ROWS][GRID_COLS];
    int                model_col;
    int                model_row;
    t_cfg              model_cfg;
    t_result           pending_results [$];
    t_result           oldest;
    int                mismatches;
    int                quiet_cycles;

    text_console_char_writer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Console model
    // ------------------------------------------------------------------

    function automatic int window_cols();
        if (model_cfg.columns == 0) return 1;
        if (model_cfg.columns > GRID_COLS) return GRID_COLS;
        return model_cfg.columns;
    endfunction

    function automatic int window_rows();
        if (model_cfg.rows == 0) return 1;
        if (model_cfg.rows > GRID_ROWS) return GRID_ROWS;
        return model_cfg.rows;
    endfunction

    task automatic model_reset();
        for (int r = 0; r < GRID_ROWS; r++) begin
            for (int k = 0; k < GRID_COLS; k++) begin
                model_grid[r][k] = CH_SPACE;
            end
        end
        model_col = 0;
        model_row = 0;
        model_cfg = '{RST_COLUMNS, RST_ROWS, RST_SCROLL_ENABLE,
                      RST_BACKSPACE_CODE, RST_ENTER_CODE};
    endtask

    // Moves to the next row; returns 1 when the grid scrolled up.
    function automatic bit model_carriage_return();
        int nr;
        nr = window_rows();
        model_col = 0;
        model_row++;
        if (model_row < nr) return 1'b0;
        model_row = nr - 1;
        if (!model_cfg.scroll_enable) return 1'b0;
        // Whole rows move up, including cells outside the column window.
        for (int r = 0; r < nr - 1; r++) begin
            for (int k = 0; k < GRID_COLS; k++) begin
                model_grid[r][k] = model_grid[r + 1][k];
            end
        end
        for (int k = 0; k < GRID_COLS; k++) begin
            model_grid[nr - 1][k] = CH_SPACE;
        end
        return 1'b1;
    endfunction

    // Applies one command to the model and returns the beat it causes.
    function automatic t_result predict_console_step(t_cmd c);
        t_result r;
        int      nc;
        r = '0;
        if (c.mode == MODE_READ) begin
            // The field widths keep every read inside the grid.
            r.cell_char = model_grid[c.read_row][c.read_col];
        end else if (c.char_code == model_cfg.backspace_code) begin
            // Backspace wins over newline and enter; no erase.
            if (model_col != 0) model_col--;
        end else if (c.char_code == CH_NEWLINE || c.char_code == model_cfg.enter_code) begin
            r.scrolled = model_carriage_return();
        end else begin
            nc = window_cols();
            // A cursor left outside a shrunken window stores nothing.
            if (model_col < nc && model_row < window_rows()) begin
                model_grid[model_row][model_col] = c.char_code;
            end
            model_col++;
            if (model_col >= nc) r.scrolled = model_carriage_return();
        end
        r.cursor_col = model_col[COL_W-1:0];
        r.cursor_row = model_row[ROW_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    function automatic t_cmd put_cmd(logic [CHAR_W-1:0] ch);
        t_cmd c;
        c           = '0;
        c.mode      = MODE_PUT;
        c.char_code = ch;
        return c;
    endfunction

    function automatic t_cmd read_cmd(int col, int row);
        t_cmd c;
        c          = '0;
        c.mode     = MODE_READ;
        c.read_col = col[COL_W-1:0];
        c.read_row = row[ROW_W-1:0];
        return c;
    endfunction

    // Presents one command beat, holds it until accepted, records the result.
    task automatic send_cmd(input t_cmd c, output t_result r);
        i_cmd <= c;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = predict_console_step(c);
        pending_results.push_back(r);
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Returns once every owed beat has arrived and the block is quiet.
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy !== 1'b0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_COLUMNS:        model_cfg.columns        = data;
            CFG_ROWS:           model_cfg.rows           = data[6:0];
            CFG_SCROLL_ENABLE:  model_cfg.scroll_enable  = data[0];
            CFG_BACKSPACE_CODE: model_cfg.backspace_code = data;
            CFG_ENTER_CODE:     model_cfg.enter_code     = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input t_cfg c);
        wait_idle();
        write_reg(CFG_COLUMNS, c.columns);
        write_reg(CFG_ROWS, {1'b0, c.rows});
        write_reg(CFG_SCROLL_ENABLE, {7'b0, c.scroll_enable});
        write_reg(CFG_BACKSPACE_CODE, c.backspace_code);
        write_reg(CFG_ENTER_CODE, c.enter_code);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Each result beat is held for one cycle only and is taken here.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: expected none, actual %h",
                         $time, o_result);
                mismatches++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("cursor_col", 8'(oldest.cursor_col), 8'(o_result.cursor_col));
                check_field("cursor_row", 8'(oldest.cursor_row), 8'(o_result.cursor_row));
                check_field("cell_char", oldest.cell_char, o_result.cell_char);
                check_field("scrolled", 8'(oldest.scrolled), 8'(o_result.scrolled));
            end
        end
    end

    // Counts cycles in which no beat moves in either direction.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Puts, reads and control codes under the reset configuration.
    task automatic test_basic_puts();
        t_result r;
        send_cmd(read_cmd(0, 0), r);
        send_cmd(read_cmd(GRID_COLS - 1, GRID_ROWS - 1), r);
        send_cmd(put_cmd(8'h48), r);
        send_cmd(put_cmd(8'h00), r);
        send_cmd(put_cmd(8'hFF), r);
        send_cmd(put_cmd(8'h7F), r);
        send_cmd(read_cmd(0, 0), r);
        send_cmd(read_cmd(3, 0), r);
        // Backspace then overwrite the same cell.
        send_cmd(put_cmd(RST_BACKSPACE_CODE), r);
        send_cmd(put_cmd(8'h55), r);
        send_cmd(read_cmd(3, 0), r);
        send_cmd(put_cmd(CH_NEWLINE), r);
        // Backspace at column 0 leaves the cursor alone.
        send_cmd(put_cmd(RST_BACKSPACE_CODE), r);
        send_cmd(put_cmd(RST_ENTER_CODE), r);
    endtask

    // Backspace, newline and enter sharing one code.
    task automatic test_code_collisions();
        t_result r;
        apply_config('{RST_COLUMNS, RST_ROWS, 1'b1, CH_NEWLINE, CH_NEWLINE});
        send_cmd(put_cmd(8'h61), r);
        send_cmd(put_cmd(CH_NEWLINE), r);
        // The old enter code is now an ordinary glyph.
        send_cmd(put_cmd(RST_ENTER_CODE), r);
        send_cmd(read_cmd(0, 2), r);
        apply_config('{RST_COLUMNS, RST_ROWS, 1'b1, 8'h41, 8'h41});
        send_cmd(put_cmd(8'h41), r);
        send_cmd(put_cmd(CH_NEWLINE), r);
    endtask

    // Zero and oversized window registers, with and without scrolling.
    task automatic test_window_extremes();
        t_result r;
        // One cell window; the cursor starts outside it.
        apply_config('{8'd0, 7'd0, 1'b1, RST_BACKSPACE_CODE, RST_ENTER_CODE});
        send_cmd(put_cmd(8'h78), r);
        send_cmd(read_cmd(0, 0), r);
        apply_config('{8'd0, 7'd0, 1'b0, RST_BACKSPACE_CODE, RST_ENTER_CODE});
        send_cmd(put_cmd(8'h79), r);
        send_cmd(read_cmd(0, 0), r);
        apply_config('{8'hFF, 7'h7F, 1'b1, RST_BACKSPACE_CODE, RST_ENTER_CODE});
        send_cmd(put_cmd(8'h7A), r);
        send_cmd(read_cmd(0, 0), r);
    endtask

    function automatic t_cfg pick_config();
        t_cfg c;
        int   sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)       c.columns = 8'd0;
        else if (sel < 14) c.columns = 8'd128;
        else if (sel < 20) c.columns = 8'($urandom_range(129, 255));
        else if (sel < 25) c.columns = 8'd1;
        else if (sel < 70) c.columns = 8'($urandom_range(2, 16));
        else               c.columns = 8'($urandom_range(17, 127));
        // Small windows keep the scroll copies short.
        sel = $urandom_range(0, 99);
        if (sel < 8)       c.rows = 7'd0;
        else if (sel < 14) c.rows = 7'd1;
        else if (sel < 60) c.rows = 7'($urandom_range(2, 6));
        else if (sel < 80) c.rows = 7'($urandom_range(7, 12));
        else if (sel < 88) c.rows = 7'($urandom_range(13, 40));
        else if (sel < 93) c.rows = 7'd64;
        else               c.rows = 7'($urandom_range(65, 127));
        c.scroll_enable = ($urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 99);
        if (sel < 40)      c.backspace_code = RST_BACKSPACE_CODE;
        else if (sel < 55) c.backspace_code = CH_NEWLINE;
        else               c.backspace_code = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 40)      c.enter_code = RST_ENTER_CODE;
        else if (sel < 55) c.enter_code = c.backspace_code;
        else if (sel < 65) c.enter_code = CH_NEWLINE;
        else               c.enter_code = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic t_cmd pick_cmd(int read_pct, int cr_pct, int bs_pct);
        t_cmd c;
        int   sel;
        c.mode      = MODE_PUT;
        c.char_code = CHAR_W'($urandom_range(0, 255));
        c.read_col  = COL_W'($urandom_range(0, GRID_COLS - 1));
        c.read_row  = ROW_W'($urandom_range(0, GRID_ROWS - 1));
        sel = $urandom_range(0, 99);
        if (sel < read_pct) begin
            c.mode = MODE_READ;
            // Half the reads aim at the window, where the writes land.
            if ($urandom_range(0, 1) != 0) begin
                c.read_col = COL_W'($urandom_range(0, window_cols() - 1));
                c.read_row = ROW_W'($urandom_range(0, window_rows() - 1));
            end
        end else if (sel < read_pct + cr_pct) begin
            c.char_code = ($urandom_range(0, 1) != 0) ? CH_NEWLINE : model_cfg.enter_code;
        end else if (sel < read_pct + cr_pct + bs_pct) begin
            c.char_code = model_cfg.backspace_code;
        end
        return c;
    endfunction

    // Random traffic in phases, each with its own register setting.
    task automatic test_random_phases();
        t_result r;
        int      sent;
        int      n_items;
        int      read_pct;
        int      cr_pct;
        int      bs_pct;
        int      phase_scrolls;
        bit      gaps_on;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            apply_config(pick_config());
            n_items  = $urandom_range(60, 140);
            read_pct = $urandom_range(10, 35);
            bs_pct   = $urandom_range(5, 15);
            // Tall windows need many returns to reach the bottom row.
            cr_pct   = (window_rows() > 8) ? $urandom_range(30, 40) : $urandom_range(5, 40);
            gaps_on  = ($urandom_range(0, 9) < 7);
            phase_scrolls = 0;
            for (int i = 0; i < n_items && sent < RANDOM_ITEMS; i++) begin
                send_cmd(pick_cmd(read_pct, cr_pct, bs_pct), r);
                sent++;
                phase_scrolls += int'(r.scrolled);
                if (gaps_on && sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
                    idle_gap($urandom_range(1, 10));
                end
                // Tall scrolls are slow; a few per phase are enough.
                if (window_rows() > 8 && phase_scrolls >= 4) break;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        mismatches   = 0;
        quiet_cycles = 0;
        model_reset();
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_cmd      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_COLUMNS;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let the clearing sweep finish before any traffic.
        repeat (2) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        test_basic_puts();
        test_code_collisions();
        test_window_extremes();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_grid_ram.sv
hdl/tcw_seq.sv
hdl/text_console_char_writer.sv
tb/text_console_char_writer_tb.sv
